>>> rtl/core/rsnh_pkg.sv
// ----------------------------------------------------------------------------
// rsnh_pkg
// Shared types, constants and helper functions of the ray/scene nearest-hit
// core: command and result records, sequencer codes, scene constants.
// ----------------------------------------------------------------------------
package rsnh_pkg;

    localparam int COORD_W     = 24;
    localparam int T_W         = 23;
    localparam int MASK_W      = 5;
    localparam int OBJ_W       = 3;
    localparam int ROUGH_W     = 5;
    localparam int MAX_SPHERES = 4;
    localparam int CFG_IDX_W   = 4;
    localparam int BEST_W      = 43;

    // Operation codes
    localparam logic OP_NEAREST = 1'b0;
    localparam logic OP_OCCLUDE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPHERE_Z_BASE = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_COUNT     = 4'd8;

    // Object codes
    localparam logic [OBJ_W-1:0] OBJ_PLANE = 3'd4;
    localparam logic [OBJ_W-1:0] OBJ_END   = 3'd5;

    // Scene constants
    localparam logic [BEST_W-1:0]  T_FAR       = 43'd6553599993447;
    localparam logic [BEST_W-1:0]  T_CLAMP     = 43'h100_0000_0000;
    localparam logic [BEST_W-1:0]  T_OUT_MAX   = 43'd8388607;
    localparam logic [53:0]        SPHERE_MIN_T = 54'd1;
    localparam logic [53:0]        PLANE_MIN_T  = 54'd7;
    localparam logic signed [24:0] PLANE_MIN_DEN = 25'sd7;
    localparam logic signed [34:0] ONE_Q16     = 35'sd65536;
    localparam logic signed [23:0] NORMAL_ONE  = 24'sd65536;
    localparam logic [ROUGH_W-1:0] PLANE_ROUGH = 5'd9;
    localparam logic [5:0]         SQRT_STEPS  = 6'd27;
    localparam logic [5:0]         DIV_STEPS   = 6'd54;

    typedef struct packed {
        logic                      operation;
        logic signed [COORD_W-1:0] ray_origin_x;
        logic signed [COORD_W-1:0] ray_origin_y;
        logic signed [COORD_W-1:0] ray_origin_z;
        logic signed [COORD_W-1:0] ray_dir_x;
        logic signed [COORD_W-1:0] ray_dir_y;
        logic signed [COORD_W-1:0] ray_dir_z;
        logic [MASK_W-1:0]         object_mask;
        logic [T_W-1:0]            t_limit;
    } rsnh_cmd_t;

    typedef struct packed {
        logic                      hit;
        logic [OBJ_W-1:0]          object_index;
        logic [T_W-1:0]            hit_t;
        logic signed [COORD_W-1:0] hit_x;
        logic signed [COORD_W-1:0] hit_y;
        logic signed [COORD_W-1:0] hit_z;
        logic signed [COORD_W-1:0] normal_x;
        logic signed [COORD_W-1:0] normal_y;
        logic signed [COORD_W-1:0] normal_z;
        logic [ROUGH_W-1:0]        roughness_index;
        logic                      occluded;
    } rsnh_result_t;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_OBJ  = 10'b00_0000_0010,
        S_MUL  = 10'b00_0000_0100,
        S_ACC  = 10'b00_0000_1000,
        S_FIN  = 10'b00_0001_0000,
        S_SQRT = 10'b00_0010_0000,
        S_NUM  = 10'b00_0100_0000,
        S_DIV  = 10'b00_1000_0000,
        S_CAND = 10'b01_0000_0000,
        S_OUT  = 10'b10_0000_0000
    } rsnh_state_t;

    typedef enum logic [2:0] {
        PASS_A,
        PASS_H,
        PASS_C,
        PASS_D,
        PASS_P
    } rsnh_pass_t;

    // Saturate a wide signed value to the Q8.16 range
    function automatic logic signed [COORD_W-1:0] sat24(input logic signed [51:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > 52'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -52'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    // Roughness index of each sphere
    function automatic logic [ROUGH_W-1:0] sphere_rough(input logic [1:0] i);
        logic [ROUGH_W-1:0] r;
        case (i)
            2'd0:    r = 5'd1;
            2'd1:    r = 5'd2;
            2'd2:    r = 5'd5;
            default: r = 5'd18;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/ray_scene_nearest_hit_core.sv
// ----------------------------------------------------------------------------
// ray_scene_nearest_hit_core
// One ray against up to four unit spheres and the ground plane: nearest hit
// with point, normal and roughness, or an occlusion test against a limit.
// ----------------------------------------------------------------------------
//  channel   ports                               transfer
//  command   start, busy, cmd                    start high while busy low
//  result    done, result                        done high for one cycle
//  config    cfg_write, cfg_index, cfg_data      cfg_write high
//
// For one ray, from its transfer to done, the core forms |d|^2, then for
// each tested sphere a 27-step square root and a 54-step divider on one
// shared subtractor, with dot products on one shared multiplier; skipped
// objects are passed over, then come the plane and the hit point.
// busy stays high meanwhile.
// Reset restores the default sphere centres and returns to idle.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module ray_scene_nearest_hit_core
    import rsnh_pkg::*;
#(
    parameter int NUM_SPHERES = 4
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  rsnh_cmd_t                 cmd,
    output logic                      done,
    output rsnh_result_t              result,
    input  logic                      cfg_write,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic signed [COORD_W-1:0] cfg_data
);

    localparam logic [OBJ_W-1:0] SPH_END = OBJ_W'(NUM_SPHERES);

    // Sequencer
    rsnh_state_t      state_reg;
    rsnh_pass_t       pass_reg;
    logic [1:0]       k_reg;
    logic [1:0]       axis_reg;
    logic [OBJ_W-1:0] obj_reg;
    logic [5:0]       it_reg;
    logic             found_reg;
    logic             occ_reg;
    logic             done_reg;
    logic [OBJ_W-1:0] idx_reg;
    logic [BEST_W-1:0] best_reg;

    // Scene configuration
    logic signed [COORD_W-1:0] sx_reg [MAX_SPHERES];
    logic signed [COORD_W-1:0] sz_reg [MAX_SPHERES];

    // Ray and datapath
    logic                      op_reg;
    logic [MASK_W-1:0]         mask_reg;
    logic [T_W-1:0]            limit_reg;
    logic signed [COORD_W-1:0] org_reg [3];
    logic signed [COORD_W-1:0] dir_reg [3];
    logic signed [24:0]        oc_reg  [3];
    logic signed [53:0]        prod_reg;
    logic signed [65:0]        acc_reg;
    logic [31:0]               a_reg;
    logic signed [34:0]        h_reg;
    logic signed [34:0]        c_reg;
    logic [53:0]               sh_reg;
    logic [33:0]               rem_reg;
    logic [26:0]               root_reg;
    logic [31:0]               den_reg;
    logic [40:0]               tc_reg;
    logic signed [50:0]        p_reg [3];
    rsnh_result_t              res_reg;

    // Combinational helpers
    logic signed [26:0] mul_a;
    logic signed [26:0] mul_b;
    logic [1:0]         last_k;
    logic signed [65:0] prod_ext;
    logic signed [65:0] acc_term;
    logic signed [65:0] acc_base;
    logic signed [65:0] acc_next;
    logic [33:0]        rem_sh;
    logic [33:0]        sub_b;
    logic [34:0]        diff;
    logic               take;
    logic signed [35:0] num;
    logic               num_pos;
    logic signed [24:0] neg_dz;
    logic               sph_en;
    logic               plane_go;
    logic [53:0]        min_t;
    logic               t_ok;
    logic signed [50:0] p_new;
    logic signed [50:0] apx;
    logic signed [50:0] apy;
    logic signed [51:0] nx;
    logic signed [51:0] nz;
    rsnh_result_t       res_next;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    // Select multiplier operands for the current pass and term
    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        last_k = 2'd2;
        case (pass_reg)
            PASS_A:
            begin
                mul_a = {{3{dir_reg[k_reg][23]}}, dir_reg[k_reg]};
                mul_b = {{3{dir_reg[k_reg][23]}}, dir_reg[k_reg]};
            end
            PASS_H:
            begin
                mul_a = {{3{dir_reg[k_reg][23]}}, dir_reg[k_reg]};
                mul_b = {{2{oc_reg[k_reg][24]}}, oc_reg[k_reg]};
            end
            PASS_C:
            begin
                mul_a = {{2{oc_reg[k_reg][24]}}, oc_reg[k_reg]};
                mul_b = {{2{oc_reg[k_reg][24]}}, oc_reg[k_reg]};
            end
            PASS_D:
            begin
                last_k = 2'd1;
                if (k_reg == 2'd0)
                begin
                    mul_a = h_reg[34:8];
                    mul_b = h_reg[34:8];
                end
                else
                begin
                    mul_a = {3'b000, a_reg[31:8]};
                    mul_b = c_reg[34:8];
                end
            end
            default:
            begin
                last_k = 2'd1;
                mul_a  = {{3{dir_reg[axis_reg][23]}}, dir_reg[axis_reg]};
                if (k_reg == 2'd0)
                    mul_b = {3'b000, tc_reg[23:0]};
                else
                    mul_b = {10'b0, tc_reg[40:24]};
            end
        endcase
    end

    // Accumulate: clear on the first term, subtract in the discriminant,
    // shift the upper half of the distance in the hit point
    always_comb
    begin
        prod_ext = {{12{prod_reg[53]}}, prod_reg};
        if (pass_reg == PASS_P && k_reg == 2'd1)
            acc_term = {prod_ext[41:0], 24'b0};
        else
            acc_term = prod_ext;
        acc_base = (k_reg == 2'd0) ? '0 : acc_reg;
        if (pass_reg == PASS_D && k_reg == 2'd1)
            acc_next = acc_base - acc_term;
        else
            acc_next = acc_base + acc_term;
    end

    // Shared compare-subtract for square root and division steps
    always_comb
    begin
        if (state_reg == S_SQRT)
        begin
            rem_sh = {rem_reg[31:0], sh_reg[53:52]};
            sub_b  = {5'b0, root_reg, 2'b01};
        end
        else
        begin
            rem_sh = {rem_reg[32:0], sh_reg[53]};
            sub_b  = {2'b00, den_reg};
        end
        diff = {1'b0, rem_sh} - {1'b0, sub_b};
        take = ~diff[34];
    end

    // Object dispatch and candidate checks
    always_comb
    begin
        num      = {h_reg[34], h_reg} - {1'b0, root_reg, 8'b0};
        num_pos  = ~num[35] && (num != '0);
        neg_dz   = -{dir_reg[2][23], dir_reg[2]};
        sph_en   = (op_reg == OP_OCCLUDE) || mask_reg[obj_reg[1:0]];
        plane_go = ((op_reg == OP_OCCLUDE) || mask_reg[MASK_W-1])
                   && (neg_dz >= PLANE_MIN_DEN) && (org_reg[2] > 24'sd0);
        min_t    = (obj_reg == OBJ_PLANE) ? PLANE_MIN_T : SPHERE_MIN_T;
        t_ok     = (sh_reg >= min_t);
        p_new    = {{27{org_reg[axis_reg][23]}}, org_reg[axis_reg]}
                   + {acc_reg[65], acc_reg[65:16]};
    end

    // Build the result record
    always_comb
    begin
        apx = p_reg[0][50] ? -p_reg[0] : p_reg[0];
        apy = p_reg[1][50] ? -p_reg[1] : p_reg[1];
        nx  = {p_reg[0][50], p_reg[0]}
              - {{28{sx_reg[idx_reg[1:0]][23]}}, sx_reg[idx_reg[1:0]]};
        nz  = {p_reg[2][50], p_reg[2]}
              - {{28{sz_reg[idx_reg[1:0]][23]}}, sz_reg[idx_reg[1:0]]};
        res_next = '0;
        if (op_reg == OP_OCCLUDE)
        begin
            res_next.occluded = occ_reg;
        end
        else if (found_reg)
        begin
            res_next.hit          = 1'b1;
            res_next.object_index = idx_reg;
            res_next.hit_t        = (best_reg > T_OUT_MAX) ? T_OUT_MAX[T_W-1:0]
                                                           : best_reg[T_W-1:0];
            res_next.hit_x        = sat24({p_reg[0][50], p_reg[0]});
            res_next.hit_y        = sat24({p_reg[1][50], p_reg[1]});
            res_next.hit_z        = sat24({p_reg[2][50], p_reg[2]});
            if (idx_reg == OBJ_PLANE)
            begin
                res_next.normal_z        = NORMAL_ONE;
                res_next.roughness_index = (apx[16] ^ apy[16]) ? '0 : PLANE_ROUGH;
            end
            else
            begin
                res_next.normal_x        = sat24(nx);
                res_next.normal_y        = sat24({p_reg[1][50], p_reg[1]});
                res_next.normal_z        = sat24(nz);
                res_next.roughness_index = sphere_rough(idx_reg[1:0]);
            end
        end
    end

    // Sequencer and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pass_reg  <= PASS_A;
            k_reg     <= '0;
            axis_reg  <= '0;
            obj_reg   <= '0;
            it_reg    <= '0;
            found_reg <= 1'b0;
            occ_reg   <= 1'b0;
            done_reg  <= 1'b0;
            idx_reg   <= '0;
            best_reg  <= T_FAR;
            sx_reg[0] <= -24'sd196608;
            sx_reg[1] <= -24'sd65536;
            sx_reg[2] <= 24'sd65536;
            sx_reg[3] <= 24'sd196608;
            sz_reg[0] <= '0;
            sz_reg[1] <= '0;
            sz_reg[2] <= '0;
            sz_reg[3] <= '0;
        end
        else
        begin
            done_reg <= 1'b0;

            // Take configuration writes; drop indexes beyond the list
            if (cfg_write)
            begin
                if (cfg_index < CFG_SPHERE_Z_BASE)
                    sx_reg[cfg_index[1:0]] <= cfg_data;
                else if (cfg_index < CFG_REG_COUNT)
                    sz_reg[cfg_index[1:0]] <= cfg_data;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        pass_reg  <= PASS_A;
                        k_reg     <= '0;
                        found_reg <= 1'b0;
                        occ_reg   <= 1'b0;
                        best_reg  <= T_FAR;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (k_reg == last_k)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= S_MUL;
                    end
                end
                S_FIN:
                begin
                    k_reg <= '0;
                    case (pass_reg)
                        PASS_A:
                        begin
                            obj_reg   <= '0;
                            state_reg <= S_OBJ;
                        end
                        PASS_H:
                        begin
                            pass_reg  <= PASS_C;
                            state_reg <= S_MUL;
                        end
                        PASS_C:
                        begin
                            pass_reg  <= PASS_D;
                            state_reg <= S_MUL;
                        end
                        PASS_D:
                        begin
                            if (a_reg == '0 || acc_reg[65])
                            begin
                                obj_reg   <= obj_reg + 3'd1;
                                state_reg <= S_OBJ;
                            end
                            else
                            begin
                                it_reg    <= '0;
                                state_reg <= S_SQRT;
                            end
                        end
                        default:
                        begin
                            if (axis_reg == 2'd2)
                            begin
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                axis_reg  <= axis_reg + 2'd1;
                                state_reg <= S_MUL;
                            end
                        end
                    endcase
                end
                S_OBJ:
                begin
                    if (obj_reg < SPH_END)
                    begin
                        if (sph_en)
                        begin
                            pass_reg  <= PASS_H;
                            k_reg     <= '0;
                            state_reg <= S_MUL;
                        end
                        else
                        begin
                            obj_reg <= obj_reg + 3'd1;
                        end
                    end
                    else if (obj_reg < OBJ_PLANE)
                    begin
                        obj_reg <= OBJ_PLANE;
                    end
                    else if (obj_reg == OBJ_PLANE)
                    begin
                        if (plane_go)
                        begin
                            it_reg    <= '0;
                            state_reg <= S_DIV;
                        end
                        else
                        begin
                            obj_reg <= OBJ_END;
                        end
                    end
                    else if (op_reg == OP_NEAREST && found_reg)
                    begin
                        pass_reg  <= PASS_P;
                        axis_reg  <= '0;
                        k_reg     <= '0;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_SQRT:
                begin
                    if (it_reg == SQRT_STEPS - 6'd1)
                        state_reg <= S_NUM;
                    else
                        it_reg <= it_reg + 6'd1;
                end
                S_NUM:
                begin
                    if (num_pos)
                    begin
                        it_reg    <= '0;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        obj_reg   <= obj_reg + 3'd1;
                        state_reg <= S_OBJ;
                    end
                end
                S_DIV:
                begin
                    if (it_reg == DIV_STEPS - 6'd1)
                        state_reg <= S_CAND;
                    else
                        it_reg <= it_reg + 6'd1;
                end
                S_CAND:
                begin
                    // Keep the earlier object on a tie
                    if (t_ok)
                    begin
                        if (op_reg == OP_OCCLUDE)
                        begin
                            if (sh_reg < {31'b0, limit_reg})
                                occ_reg <= 1'b1;
                        end
                        else if (sh_reg < {11'b0, best_reg})
                        begin
                            best_reg  <= sh_reg[BEST_W-1:0];
                            idx_reg   <= obj_reg;
                            found_reg <= 1'b1;
                        end
                    end
                    obj_reg   <= obj_reg + 3'd1;
                    state_reg <= S_OBJ;
                end
                S_OUT:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_reg     <= cmd.operation;
                    mask_reg   <= cmd.object_mask;
                    limit_reg  <= cmd.t_limit;
                    org_reg[0] <= cmd.ray_origin_x;
                    org_reg[1] <= cmd.ray_origin_y;
                    org_reg[2] <= cmd.ray_origin_z;
                    dir_reg[0] <= cmd.ray_dir_x;
                    dir_reg[1] <= cmd.ray_dir_y;
                    dir_reg[2] <= cmd.ray_dir_z;
                end
            end
            S_MUL:
            begin
                prod_reg <= mul_a * mul_b;
            end
            S_ACC:
            begin
                acc_reg <= acc_next;
            end
            S_FIN:
            begin
                case (pass_reg)
                    PASS_A: a_reg <= acc_reg[47:16];
                    PASS_H: h_reg <= acc_reg[50:16];
                    PASS_C: c_reg <= {1'b0, acc_reg[49:16]} - ONE_Q16;
                    PASS_D:
                    begin
                        sh_reg   <= acc_reg[53:0];
                        rem_reg  <= '0;
                        root_reg <= '0;
                    end
                    default: p_reg[axis_reg] <= p_new;
                endcase
            end
            S_OBJ:
            begin
                // Load centre offsets, plane divider and clamped distance
                oc_reg[0] <= {sx_reg[obj_reg[1:0]][23], sx_reg[obj_reg[1:0]]}
                             - {org_reg[0][23], org_reg[0]};
                oc_reg[1] <= -{org_reg[1][23], org_reg[1]};
                oc_reg[2] <= {sz_reg[obj_reg[1:0]][23], sz_reg[obj_reg[1:0]]}
                             - {org_reg[2][23], org_reg[2]};
                sh_reg    <= {15'b0, org_reg[2][22:0], 16'b0};
                rem_reg   <= '0;
                den_reg   <= {8'b0, neg_dz[23:0]};
                tc_reg    <= (best_reg >= T_CLAMP) ? T_CLAMP[40:0] : best_reg[40:0];
            end
            S_SQRT:
            begin
                rem_reg  <= take ? diff[33:0] : rem_sh;
                root_reg <= {root_reg[25:0], take};
                sh_reg   <= {sh_reg[51:0], 2'b00};
            end
            S_NUM:
            begin
                sh_reg  <= {4'b0, num[33:0], 16'b0};
                rem_reg <= '0;
                den_reg <= a_reg;
            end
            S_DIV:
            begin
                rem_reg <= take ? diff[33:0] : rem_sh;
                sh_reg  <= {sh_reg[52:0], take};
            end
            S_OUT:
            begin
                res_reg <= res_next;
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
    end

    // Checks
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_mode_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.hit && result.occluded))
        else $error("hit and occluded both set");

    a_sqrt_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQRT) |-> (it_reg < SQRT_STEPS))
        else $error("square root step count overrun");

    a_cand_obj: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CAND) |-> (obj_reg <= OBJ_PLANE))
        else $error("candidate from no object");

endmodule
